// File: sv/utf8wt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte classification functions for the UTF-8 word tokenizer.
// Used by utf8wt_pos_counter, utf8wt_word_tracker and utf8_word_tokenizer_classifier.
package utf8wt_pkg;

    localparam longint unsigned MAX_TEXT_BYTES_DEF = 64'd1048576;
    localparam longint unsigned MAX_LINES_DEF      = 64'd65536;

    localparam int POS_W  = 20;
    localparam int LEN_W  = 21;
    localparam int LINE_W = 16;
    localparam int COL_W  = 16;

    localparam int TDATA_W = 120;
    localparam int TUSER_W = 5;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] CHR_AT     = 8'h40;
    localparam logic [7:0] CHR_DOT    = 8'h2E;
    localparam logic [7:0] CHR_USCORE = 8'h5F;
    localparam logic [7:0] CHR_APOS   = 8'h27;
    localparam logic [7:0] CHR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHR_NL     = 8'h0A;

    localparam logic [7:0] WWW_PREFIX [4] = '{8'h77, 8'h77, 8'h77, 8'h2E};
    localparam logic [2:0] WWW_LEN = 3'd4;

    typedef struct packed {
        logic [POS_W-1:0]  byte_pos;
        logic [POS_W-1:0]  char_pos;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } pos_t;

    typedef struct packed {
        logic [LEN_W-1:0] bytes;
        logic [LEN_W-1:0] chars;
        logic             digit;
        logic             upper;
        logic             lower;
        logic             upper_late;
        logic             non_ascii;
        logic             underscore;
        logic             at;
        logic             dot_url;
        logic [2:0]       www_matched;
        logic             www_failed;
        logic             dot_seen;
        logic             dot_pending;
        logic             prev_alpha;
    } acc_t;

    // One byte moving from the input register into the state logic
    typedef struct packed {
        logic       adv;
        logic [7:0] data;
        logic       last;
    } step_t;

    typedef struct packed {
        logic [POS_W-1:0]  start_byte;
        logic [LEN_W-1:0]  byte_length;
        logic [POS_W-1:0]  start_char;
        logic [LEN_W-1:0]  char_length;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column_number;
        logic              has_digit;
        logic              all_upper;
        logic              mixed_case;
        logic              has_underscore;
        logic              url_like;
    } result_t;

    function automatic logic is_upper(logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return is_upper(c) || is_lower(c);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c[7];
    endfunction

    function automatic logic is_joiner(logic [7:0] c);
        return (c == CHR_APOS) || (c == CHR_HYPHEN) || (c == CHR_USCORE) ||
               (c == CHR_DOT) || (c == CHR_AT);
    endfunction

    function automatic logic is_lead(logic [7:0] c);
        return (c & CONT_MASK) != CONT_CODE;
    endfunction

    // Fold one byte into the word accumulators; lengths saturate at lim
    function automatic acc_t append_byte(acc_t a, logic [7:0] c, logic [LEN_W-1:0] lim);
        acc_t r;
        logic alpha;
        r     = a;
        alpha = is_alpha(c);
        if (is_digit(c)) r.digit = 1'b1;
        if (c[7]) r.non_ascii = 1'b1;
        if (is_lower(c)) r.lower = 1'b1;
        if (is_upper(c)) begin
            r.upper = 1'b1;
            if (a.bytes != '0) r.upper_late = 1'b1;
        end
        if (c == CHR_USCORE) r.underscore = 1'b1;
        if (c == CHR_AT) r.at = 1'b1;
        if ((a.bytes < LEN_W'(4)) && !a.www_failed) begin
            if (c == WWW_PREFIX[a.bytes[1:0]]) r.www_matched = a.www_matched + 3'd1;
            else r.www_failed = 1'b1;
        end
        if (a.dot_pending) begin
            if (alpha) r.dot_url = 1'b1;
            r.dot_pending = 1'b0;
        end
        if ((c == CHR_DOT) && !a.dot_seen) begin
            r.dot_seen    = 1'b1;
            r.dot_pending = a.prev_alpha;
        end
        r.prev_alpha = alpha;
        if (a.bytes < lim) r.bytes = a.bytes + LEN_W'(1);
        if (is_lead(c) && (a.chars < lim)) r.chars = a.chars + LEN_W'(1);
        return r;
    endfunction

endpackage

// File: sv/utf8wt_pos_counter.sv
`timescale 1ns / 1ps
// Running byte, codepoint, line and column counters of the text stream.
// Depends on utf8wt_pkg for pos_t, step_t and the byte constants.
module utf8wt_pos_counter #(
    parameter longint unsigned MAX_TEXT_BYTES = utf8wt_pkg::MAX_TEXT_BYTES_DEF,
    parameter longint unsigned MAX_LINES      = utf8wt_pkg::MAX_LINES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  utf8wt_pkg::step_t   step,
    output utf8wt_pkg::pos_t    pos
);

    localparam logic [utf8wt_pkg::POS_W:0] POS_LIMIT =
        (MAX_TEXT_BYTES < 64'h100000) ? (utf8wt_pkg::POS_W+1)'(MAX_TEXT_BYTES)
                                      : (utf8wt_pkg::POS_W+1)'(64'h100000);
    localparam logic [utf8wt_pkg::LINE_W-1:0] LINE_MAX =
        (MAX_LINES < 64'h10000) ? utf8wt_pkg::LINE_W'(MAX_LINES - 64'd1) : '1;

    utf8wt_pkg::pos_t pos_reg;
    utf8wt_pkg::pos_t pos_next;

    logic [utf8wt_pkg::POS_W:0] byte_inc;
    logic [utf8wt_pkg::POS_W:0] char_inc;

    always_comb begin
        pos_next = pos_reg;
        byte_inc = {1'b0, pos_reg.byte_pos} + (utf8wt_pkg::POS_W+1)'(1);
        char_inc = {1'b0, pos_reg.char_pos} + (utf8wt_pkg::POS_W+1)'(1);
        if (utf8wt_pkg::is_lead(step.data)) begin
            pos_next.char_pos = (char_inc >= POS_LIMIT) ? '0 : char_inc[utf8wt_pkg::POS_W-1:0];
            if (step.data == utf8wt_pkg::CHR_NL) begin
                if (pos_reg.line < LINE_MAX) pos_next.line = pos_reg.line + 16'd1;
                pos_next.col = '0;
            end else if (pos_reg.col != '1) begin
                pos_next.col = pos_reg.col + 16'd1;
            end
        end
        pos_next.byte_pos = (byte_inc >= POS_LIMIT) ? '0 : byte_inc[utf8wt_pkg::POS_W-1:0];
        // end of text: start the next text from zero
        if (step.last) pos_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (step.adv) begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

// File: sv/utf8wt_word_tracker.sv
`timescale 1ns / 1ps
// Word boundary tracking, joiner hold and flag accumulation; builds the result of a word.
// Depends on utf8wt_pkg for acc_t, pos_t, step_t, result_t and append_byte.
module utf8wt_word_tracker #(
    parameter longint unsigned MAX_TEXT_BYTES = utf8wt_pkg::MAX_TEXT_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  utf8wt_pkg::step_t    step,
    input  utf8wt_pkg::pos_t     pos,
    output logic                 emit,
    output utf8wt_pkg::result_t  result
);

    localparam logic [utf8wt_pkg::LEN_W-1:0] LEN_LIMIT =
        (MAX_TEXT_BYTES < 64'h100000) ? utf8wt_pkg::LEN_W'(MAX_TEXT_BYTES)
                                      : utf8wt_pkg::LEN_W'(64'h100000);

    logic              in_word_reg,  in_word_next;
    logic              held_vld_reg, held_vld_next;
    logic [7:0]        held_reg,     held_next;
    utf8wt_pkg::pos_t  start_reg,    start_next;
    utf8wt_pkg::acc_t  acc_reg,      acc_next;

    logic c_word;
    logic end_word;
    logic www;

    always_comb begin
        c_word        = utf8wt_pkg::is_word(step.data);
        end_word      = 1'b0;
        in_word_next  = in_word_reg;
        held_vld_next = held_vld_reg;
        held_next     = held_reg;
        start_next    = start_reg;
        acc_next      = acc_reg;
        if (in_word_reg) begin
            if (held_vld_reg) begin
                if (c_word) begin
                    // joiner stays: fold it in, then this byte
                    acc_next = utf8wt_pkg::append_byte(
                        utf8wt_pkg::append_byte(acc_reg, held_reg, LEN_LIMIT),
                        step.data, LEN_LIMIT);
                    held_vld_next = 1'b0;
                    held_next     = '0;
                end else begin
                    end_word = 1'b1;
                end
            end else if (c_word) begin
                acc_next = utf8wt_pkg::append_byte(acc_reg, step.data, LEN_LIMIT);
            end else if (utf8wt_pkg::is_joiner(step.data)) begin
                held_next     = step.data;
                held_vld_next = 1'b1;
            end else begin
                end_word = 1'b1;
            end
        end else if (c_word) begin
            start_next   = pos;
            acc_next     = utf8wt_pkg::append_byte('0, step.data, LEN_LIMIT);
            in_word_next = 1'b1;
        end
        emit = end_word || (step.last && in_word_next);
        if (end_word) begin
            in_word_next  = 1'b0;
            held_vld_next = 1'b0;
            held_next     = '0;
        end
    end

    always_comb begin
        www = !acc_next.www_failed && (acc_next.www_matched == utf8wt_pkg::WWW_LEN);
        result.start_byte     = start_next.byte_pos;
        result.byte_length    = acc_next.bytes;
        result.start_char     = start_next.char_pos;
        result.char_length    = acc_next.chars;
        result.line_number    = start_next.line;
        result.column_number  = start_next.col;
        result.has_digit      = acc_next.digit;
        result.all_upper      = acc_next.upper && !acc_next.lower && !acc_next.non_ascii;
        result.mixed_case     = acc_next.upper_late && acc_next.lower;
        result.has_underscore = acc_next.underscore;
        result.url_like       = acc_next.at || www || acc_next.dot_url;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg  <= 1'b0;
            held_vld_reg <= 1'b0;
            held_reg     <= '0;
            start_reg    <= '0;
            acc_reg      <= '0;
        end else if (step.adv) begin
            if (step.last) begin
                in_word_reg  <= 1'b0;
                held_vld_reg <= 1'b0;
                held_reg     <= '0;
                start_reg    <= '0;
                acc_reg      <= '0;
            end else begin
                in_word_reg  <= in_word_next;
                held_vld_reg <= held_vld_next;
                held_reg     <= held_next;
                start_reg    <= start_next;
                acc_reg      <= acc_next;
            end
        end
    end

endmodule

// File: sv/utf8_word_tokenizer_classifier.sv
`timescale 1ns / 1ps
// UTF-8 word tokenizer and classifier: the input register feeds the word and position logic,
// whose result lands in the output register. Throughput one byte per cycle while the output
// register is free; stalls on the result side only hold the input when the output register
// is still occupied.
// Reset: synchronous aresetn clears counters, word state and both valid flags.
module utf8_word_tokenizer_classifier #(
    parameter longint unsigned MAX_TEXT_BYTES = utf8wt_pkg::MAX_TEXT_BYTES_DEF,
    parameter longint unsigned MAX_LINES      = utf8wt_pkg::MAX_LINES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] data_byte
    input  logic                               s_tlast,  // end_of_text
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [19:0] start_byte, [40:20] byte_length, [60:41] start_char, [81:61] char_length,
    // [97:82] line_number, [113:98] column_number, [119:114] zero
    output logic [utf8wt_pkg::TDATA_W-1:0]     m_tdata,
    // [0] has_digit, [1] all_upper, [2] mixed_case, [3] has_underscore, [4] url_like
    output logic [utf8wt_pkg::TUSER_W-1:0]     m_tuser
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_vld_reg;
    logic [utf8wt_pkg::TDATA_W-1:0] out_data_reg;
    logic [utf8wt_pkg::TUSER_W-1:0] out_user_reg;

    logic                 out_free;
    utf8wt_pkg::step_t    step;
    utf8wt_pkg::pos_t     pos;
    logic                 emit;
    utf8wt_pkg::result_t  result;

    assign out_free  = !out_vld_reg || m_tready;
    assign step.adv  = in_vld_reg && out_free;
    assign step.data = in_byte_reg;
    assign step.last = in_last_reg;
    assign s_tready  = !in_vld_reg || out_free;

    utf8wt_pos_counter #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .MAX_LINES      (MAX_LINES)
    ) u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .pos     (pos)
    );

    utf8wt_word_tracker #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_word (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .pos     (pos),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (step.adv && emit) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // load the result only when a word closes
    always_ff @(posedge aclk) begin
        if (step.adv && emit) begin
            out_data_reg <= {6'b0, result.column_number, result.line_number,
                             result.char_length, result.start_char,
                             result.byte_length, result.start_byte};
            out_user_reg <= {result.url_like, result.has_underscore, result.mixed_case,
                             result.all_upper, result.has_digit};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[40:20] != '0))
        else $error("word result with zero byte length");

    a_chars_le_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[81:61] <= m_tdata[40:20]))
        else $error("char length exceeds byte length");

    a_case_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[1] && m_tuser[2]))
        else $error("all_upper and mixed_case both set");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_free) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("input register changed while stalled");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for utf8_word_tokenizer_classifier: byte stream in, one word record out per word.
// Depends on utf8wt_pkg for widths, character constants and the result_t layout.
module tb_top;
    import utf8wt_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_GOAL = 1450;
    localparam logic [LEN_W-1:0] LEN_CAP = 21'h100000;
    localparam logic [LINE_W-1:0] LINE_TOP = 16'hFFFF;
    localparam logic [COL_W-1:0] COL_TOP = 16'hFFFF;
    localparam logic [7:0] CHR_W = 8'h77;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    // Word predictor and store of the word records still owed by the block
    class word_scoreboard;
        logic [POS_W-1:0] byte_pos, char_pos;
        logic [LINE_W-1:0] line_cnt;
        logic [COL_W-1:0] col_cnt;
        bit in_word, held_valid;
        logic [7:0] held;
        logic [POS_W-1:0] st_byte, st_char;
        logic [LINE_W-1:0] st_line;
        logic [COL_W-1:0] st_col;
        logic [LEN_W-1:0] n_bytes, n_chars;
        bit saw_digit, saw_upper, saw_lower, saw_upper_late, saw_non_ascii;
        bit saw_uscore, saw_at, dot_url;
        int www_hits;
        bit www_broken, dot_seen, dot_pending, prev_alpha;
        result_t words_due[$];
        int errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function bit is_up(logic [7:0] c);
            return c >= 8'h41 && c <= 8'h5A;
        endfunction

        function bit is_lo(logic [7:0] c);
            return c >= 8'h61 && c <= 8'h7A;
        endfunction

        function bit is_letter(logic [7:0] c);
            return is_up(c) || is_lo(c);
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function bit is_joiner_byte(logic [7:0] c);
            return c == CHR_APOS || c == CHR_HYPHEN || c == CHR_USCORE ||
                   c == CHR_DOT || c == CHR_AT;
        endfunction

        function void clear_word();
            n_bytes = '0;
            n_chars = '0;
            {saw_digit, saw_upper, saw_lower, saw_upper_late} = '0;
            {saw_non_ascii, saw_uscore, saw_at, dot_url} = '0;
            www_hits = 0;
            {www_broken, dot_seen, dot_pending, prev_alpha} = '0;
        endfunction

        function void clear();
            byte_pos = '0;
            char_pos = '0;
            line_cnt = '0;
            col_cnt = '0;
            in_word = 1'b0;
            held_valid = 1'b0;
            held = '0;
            st_byte = '0;
            st_char = '0;
            st_line = '0;
            st_col = '0;
            clear_word();
        endfunction

        function void fold_byte(logic [7:0] c);
            logic [7:0] www_char;
            bit alpha;
            alpha = is_letter(c);
            www_char = (n_bytes == 3) ? CHR_DOT : CHR_W;
            if (is_num(c)) saw_digit = 1'b1;
            if (c[7]) saw_non_ascii = 1'b1;
            if (is_lo(c)) saw_lower = 1'b1;
            if (is_up(c)) begin
                saw_upper = 1'b1;
                if (n_bytes != 0) saw_upper_late = 1'b1;
            end
            if (c == CHR_USCORE) saw_uscore = 1'b1;
            if (c == CHR_AT) saw_at = 1'b1;
            if (n_bytes < 4 && !www_broken) begin
                if (c == www_char) www_hits++;
                else www_broken = 1'b1;
            end
            // a letter straight after the first dot completes the dotted-name test
            if (dot_pending) begin
                if (alpha) dot_url = 1'b1;
                dot_pending = 1'b0;
            end
            if (c == CHR_DOT && !dot_seen) begin
                dot_seen = 1'b1;
                dot_pending = prev_alpha;
            end
            prev_alpha = alpha;
            if (n_bytes < LEN_CAP) n_bytes++;
            if ((c & CONT_MASK) != CONT_CODE && n_chars < LEN_CAP) n_chars++;
        endfunction

        function void count_byte(logic [7:0] c);
            if ((c & CONT_MASK) != CONT_CODE) begin
                char_pos = char_pos + 1'b1;
                if (c == CHR_NL) begin
                    if (line_cnt < LINE_TOP) line_cnt++;
                    col_cnt = '0;
                end else if (col_cnt < COL_TOP) begin
                    col_cnt++;
                end
            end
            byte_pos = byte_pos + 1'b1;
        endfunction

        function void close_word();
            result_t r;
            r.start_byte = st_byte;
            r.byte_length = n_bytes;
            r.start_char = st_char;
            r.char_length = n_chars;
            r.line_number = st_line;
            r.column_number = st_col;
            r.has_digit = saw_digit;
            r.all_upper = saw_upper && !saw_lower && !saw_non_ascii;
            r.mixed_case = saw_upper_late && saw_lower;
            r.has_underscore = saw_uscore;
            r.url_like = saw_at || (!www_broken && www_hits == 4) || dot_url;
            words_due.insert(words_due.size(), r);
            in_word = 1'b0;
            held_valid = 1'b0;
            held = '0;
        endfunction

        // Note one accepted input transaction
        function void note_byte(logic [7:0] c, bit last);
            bit wb;
            wb = is_letter(c) || is_num(c) || c[7];
            if (in_word) begin
                if (held_valid) begin
                    if (wb) begin
                        fold_byte(held);
                        fold_byte(c);
                        held_valid = 1'b0;
                        held = '0;
                    end else begin
                        close_word();
                    end
                end else if (wb) begin
                    fold_byte(c);
                end else if (is_joiner_byte(c)) begin
                    held = c;
                    held_valid = 1'b1;
                end else begin
                    close_word();
                end
            end else if (wb) begin
                st_byte = byte_pos;
                st_char = char_pos;
                st_line = line_cnt;
                st_col = col_cnt;
                clear_word();
                in_word = 1'b1;
                fold_byte(c);
            end
            count_byte(c);
            if (last) begin
                if (in_word) close_word();
                clear();
            end
        endfunction

        function void fault(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void cmp_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) fault($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        // Check one accepted result transaction against the oldest owed word
        function void check_word(logic [TDATA_W-1:0] td, logic [TUSER_W-1:0] tu);
            result_t want;
            if (words_due.size() == 0) begin
                fault($sformatf("word record with none owed, tdata %h tuser %b", td, tu));
                return;
            end
            want = words_due[0];
            words_due.delete(0);
            cmp_field("start_byte", want.start_byte, td[19:0]);
            cmp_field("byte_length", want.byte_length, td[40:20]);
            cmp_field("start_char", want.start_char, td[60:41]);
            cmp_field("char_length", want.char_length, td[81:61]);
            cmp_field("line_number", want.line_number, td[97:82]);
            cmp_field("column_number", want.column_number, td[113:98]);
            cmp_field("has_digit", want.has_digit, tu[0]);
            cmp_field("all_upper", want.all_upper, tu[1]);
            cmp_field("mixed_case", want.mixed_case, tu[2]);
            cmp_field("has_underscore", want.has_underscore, tu[3]);
            cmp_field("url_like", want.url_like, tu[4]);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;

    word_scoreboard sb;
    logic [7:0] text_q[$];
    int bytes_sent = 0;
    int idle_cycles = 0;
    int tx_run = 0;
    int rx_run = 0;
    bit tx_calm = 1'b0;
    bit rx_hold_req = 1'b0;

    utf8_word_tokenizer_classifier DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Gap before the next transaction; runs of zero gaps now and then
    function automatic int pick_gap(input bit calm, inout int run);
        if (calm) return 0;
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            run = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] rnd_char(input int mode);
        case (mode)
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return ($urandom_range(0, 1) == 0) ? 8'h61 + 8'($urandom_range(0, 25))
                                                 : 8'h41 + 8'($urandom_range(0, 25));
            default: return ($urandom_range(0, 2) == 0) ? 8'h30 + 8'($urandom_range(0, 9))
                                                       : 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rnd_joiner();
        case ($urandom_range(0, 4))
            0: return CHR_APOS;
            1: return CHR_HYPHEN;
            2: return CHR_USCORE;
            3: return CHR_DOT;
            default: return CHR_AT;
        endcase
    endfunction

    function automatic logic [7:0] rnd_sep();
        case ($urandom_range(0, 8))
            0, 1: return CHR_SPACE;
            2: return CHR_NL;
            3: return 8'h2C;
            4: return 8'h09;
            5: return 8'h21;
            6: return 8'h28;
            7: return 8'h00;
            default: return 8'h7F;
        endcase
    endfunction

    // Append one byte to the queued text
    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic push_run(input int n, input int mode);
        repeat (n) add_byte(rnd_char(mode));
    endtask

    task automatic push_utf8();
        case ($urandom_range(0, 2))
            0: begin
                add_byte(8'hC2 + 8'($urandom_range(0, 29)));
                add_byte(8'h80 + 8'($urandom_range(0, 63)));
            end
            1: begin
                add_byte(8'hE2);
                add_byte(8'h82);
                add_byte(8'hAC);
            end
            default: begin
                add_byte(8'hF0);
                add_byte(8'h9F);
                add_byte(8'h98);
                add_byte(8'h80 + 8'($urandom_range(0, 63)));
            end
        endcase
    endtask

    task automatic add_piece();
        case ($urandom_range(0, 13))
            0: push_run($urandom_range(1, 8), 0);
            1: push_run($urandom_range(1, 6), 1);
            2: push_run($urandom_range(2, 8), 2);
            3: push_run($urandom_range(1, 6), 3);
            4: begin
                if ($urandom_range(0, 1) == 0) push_run($urandom_range(1, 3), 2);
                repeat ($urandom_range(1, 3)) push_utf8();
            end
            5: begin
                push_run($urandom_range(1, 5), 2);
                add_byte(rnd_joiner());
                push_run($urandom_range(1, 5), 3);
            end
            6: begin
                repeat (3) add_byte(CHR_W);
                add_byte(CHR_DOT);
                push_run($urandom_range(1, 6), 0);
                add_byte(CHR_DOT);
                push_run($urandom_range(2, 3), 0);
            end
            7: begin
                push_run($urandom_range(1, 6), 3);
                add_byte(CHR_AT);
                push_run($urandom_range(1, 6), 0);
                add_byte(CHR_DOT);
                push_run($urandom_range(2, 3), 0);
            end
            8: begin
                push_run($urandom_range(1, 5), $urandom_range(0, 3));
                add_byte(CHR_DOT);
                push_run($urandom_range(1, 5), $urandom_range(0, 3));
            end
            9: begin
                push_run($urandom_range(1, 4), 0);
                add_byte(rnd_joiner());
                add_byte(rnd_joiner());
                push_run($urandom_range(1, 4), 0);
            end
            10: begin
                push_run($urandom_range(1, 5), 2);
                add_byte(rnd_joiner());
            end
            11: begin
                repeat ($urandom_range(1, 3)) add_byte(8'h80 + 8'($urandom_range(0, 63)));
                push_run($urandom_range(0, 4), 2);
            end
            12: begin
                push_run($urandom_range(1, 4), 2);
                add_byte(CHR_USCORE);
                push_run($urandom_range(1, 4), 0);
                add_byte(CHR_USCORE);
                push_run($urandom_range(1, 4), 3);
            end
            default: begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic build_text();
        text_q.delete();
        if ($urandom_range(0, 3) == 0) add_byte(rnd_sep());
        repeat ($urandom_range(1, 10)) begin
            add_piece();
            if ($urandom_range(0, 5) != 0) add_byte(rnd_sep());
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = pick_gap(tx_calm, tx_run);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Send the queued text, end_of_text on its final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
        send_text();
    endtask

    // Drop valid and hold until every owed word record has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.words_due.size() != 0) @(posedge aclk);
    endtask

    // Result side: random ready gaps, plus one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (rx_hold_req) begin
                gap = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                gap = pick_gap(1'b0, rx_run);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Watch both channels and the idle watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: case flags, trailing joiner, joiner pair, continuation start
        send_string("AB9 ");
        send_string("aB-c.");
        send_string("x..y\n");
        text_q = '{8'h80, 8'hBF, 8'hC3, 8'hA9, 8'hFF};
        send_text();
        send_string("www.q");
        wait_drained();

        // hold the result side while words keep arriving so the input stalls
        tx_calm = 1'b1;
        rx_hold_req = 1'b1;
        text_q.delete();
        repeat (20) begin
            push_run(2, 2);
            add_byte(CHR_SPACE);
        end
        send_text();
        tx_calm = 1'b0;
        wait_drained();

        while (bytes_sent < ITEM_GOAL) begin
            build_text();
            send_text();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge aclk);

        if (sb.errors == 0 && sb.words_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
